@@ hw/rtl/refcounted_tag_cache_top_assert.svh @@
// Assertion macros used by the tag cache controller (rtc_ctrl)
`ifndef REFCOUNTED_TAG_CACHE_TOP_ASSERT_SVH
`define REFCOUNTED_TAG_CACHE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst
`define RTC_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define RTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rtc_pkg.sv @@
// Types and codes for the reference-counted tag cache
`timescale 1ns / 1ps
`default_nettype none

package rtc_pkg;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_ACQUIRE = 2'd0;
  localparam cmd_t CMD_ADDREF  = 2'd1;
  localparam cmd_t CMD_RELEASE = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t STAT_DONE     = 2'd0;
  localparam status_t STAT_CLAIMED  = 2'd1;
  localparam status_t STAT_FULL     = 2'd2;
  localparam status_t STAT_REL_ZERO = 2'd3;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [31:0] obj;
    logic [15:0] dev;
    logic [15:0] count;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_SLOT_RD,
    S_SLOT_OP,
    S_MTF,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/refcounted_tag_cache_top.sv @@
// Top level of the reference-counted tag cache
//
// Input channel s_*: one beat per command. s_tuser carries cmd (0 acquire by
// tag, 1 add reference, 2 release). Output channel m_*: exactly one result
// beat per command, in command order; m_tuser carries the status code.
// Commands are processed one at a time; s_tready is high while idle.
// Acquire walks the recency list front to back through the order memory and
// then the entry memory, one position per cycle, until a match or the end of
// the list; the block takes the next command once the result is loaded into
// the output register. Add-reference and release read the slot's entry and
// then update its count; a release that drops a count to zero also runs the
// move-to-front pass over the order memory, down to the slot's list
// position.
// A finished result sits in the output register; the next command is accepted
// while it waits, and that command holds before its own result until m_tready.
// Reset (rst, synchronous) clears all tags and counts to zero and restores
// the order list to slot i at position i through per-entry valid bits, so the
// block accepts commands as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module refcounted_tag_cache_top
  import rtc_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // object_number[31:0], device_number[47:32],
                                      // slot_index[52:48], zero pad[55:53]
  input  wire logic [1:0]  s_tuser,   // cmd[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // result_slot[4:0], count_after[20:5], zero pad[23:21]
  output logic [1:0]       m_tuser    // status[1:0]
);

  localparam int AW = $clog2(ENTRIES);

  entry_t        entry_rd_data, entry_wr_data;
  logic          entry_rd_en, entry_wr_en;
  logic [AW-1:0] entry_rd_addr, entry_wr_addr;
  logic          order_rd_en, order_wr_en;
  logic [AW-1:0] order_rd_addr, order_wr_addr, order_rd_data, order_wr_data;
  logic [4:0]    out_slot;
  status_t       out_status;
  logic [15:0]   out_count;

  rtc_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_cmd        (s_tuser),
    .in_obj        (s_tdata[31:0]),
    .in_dev        (s_tdata[47:32]),
    .in_slot       (s_tdata[52:48]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_slot      (out_slot),
    .out_status    (out_status),
    .out_count     (out_count),
    .entry_rd_en   (entry_rd_en),
    .entry_rd_addr (entry_rd_addr),
    .entry_rd_data (entry_rd_data),
    .entry_wr_en   (entry_wr_en),
    .entry_wr_addr (entry_wr_addr),
    .entry_wr_data (entry_wr_data),
    .order_rd_en   (order_rd_en),
    .order_rd_addr (order_rd_addr),
    .order_rd_data (order_rd_data),
    .order_wr_en   (order_wr_en),
    .order_wr_addr (order_wr_addr),
    .order_wr_data (order_wr_data)
  );

  rtc_entry_mem #(.ENTRIES(ENTRIES)) u_entry_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (entry_rd_en),
    .rd_addr (entry_rd_addr),
    .rd_data (entry_rd_data),
    .wr_en   (entry_wr_en),
    .wr_addr (entry_wr_addr),
    .wr_data (entry_wr_data)
  );

  rtc_order_mem #(.ENTRIES(ENTRIES)) u_order_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (order_rd_en),
    .rd_addr (order_rd_addr),
    .rd_data (order_rd_data),
    .wr_en   (order_wr_en),
    .wr_addr (order_wr_addr),
    .wr_data (order_wr_data)
  );

  assign m_tdata = {3'b000, out_count, out_slot};
  assign m_tuser = out_status;

endmodule

`default_nettype wire

@@ hw/rtl/rtc_entry_mem.sv @@
// Tag and count memory with per-entry valid bits standing in for the cleared reset
`timescale 1ns / 1ps
`default_nettype none

module rtc_entry_mem
  import rtc_pkg::*;
#(
  parameter int ENTRIES = 32,
  localparam int AW = $clog2(ENTRIES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data
);

  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] valid;
  entry_t             rd_raw;
  logic               rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw   <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  // an entry never written reads as the cleared tag and count
  assign rd_data = rd_valid ? rd_raw : '0;

endmodule

`default_nettype wire

@@ hw/rtl/rtc_order_mem.sv @@
// Recency order memory; a position never written reads as its own index
`timescale 1ns / 1ps
`default_nettype none

module rtc_order_mem #(
  parameter int ENTRIES = 32,
  localparam int AW = $clog2(ENTRIES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [AW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [AW-1:0] wr_data
);

  logic [AW-1:0]      mem [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [AW-1:0]      rd_raw;
  logic [AW-1:0]      rd_addr_q;
  logic               rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw    <= mem[rd_addr];
      rd_valid  <= valid[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  assign rd_data = rd_valid ? rd_raw : rd_addr_q;

endmodule

`default_nettype wire

@@ hw/rtl/rtc_ctrl.sv @@
// Command sequencer: list scan, count update, move-to-front and result register
`timescale 1ns / 1ps
`default_nettype none
`include "refcounted_tag_cache_top_assert.svh"

module rtc_ctrl
  import rtc_pkg::*;
#(
  parameter int ENTRIES = 32,
  localparam int AW = $clog2(ENTRIES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cmd_t          in_cmd,
  input  wire logic [31:0]   in_obj,
  input  wire logic [15:0]   in_dev,
  input  wire logic [4:0]    in_slot,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [4:0]         out_slot,
  output status_t            out_status,
  output logic [15:0]        out_count,
  output logic               entry_rd_en,
  output logic [AW-1:0]      entry_rd_addr,
  input  wire entry_t        entry_rd_data,
  output logic               entry_wr_en,
  output logic [AW-1:0]      entry_wr_addr,
  output entry_t             entry_wr_data,
  output logic               order_rd_en,
  output logic [AW-1:0]      order_rd_addr,
  input  wire logic [AW-1:0] order_rd_data,
  output logic               order_wr_en,
  output logic [AW-1:0]      order_wr_addr,
  output logic [AW-1:0]      order_wr_data
);

  localparam logic [AW:0] ENTRIES_W = (AW+1)'(ENTRIES);
  localparam logic [AW:0] LAST_POS  = (AW+1)'(ENTRIES - 1);

  state_t state, state_next;

  cmd_t        cmd_q;
  logic [31:0] obj_q;
  logic [15:0] dev_q;
  logic [AW-1:0] slot_q;

  logic [AW:0]   rd_pos;
  logic          s1, s1_last, s2, s2_last;
  logic [AW-1:0] s1_pos, s2_slot;
  logic          hit, have_free;
  logic [AW-1:0] hit_slot, free_slot, carry;
  logic [15:0]   hit_count;

  logic [4:0]  res_slot, res_slot_next;
  status_t     res_status, res_status_next;
  logic [15:0] res_count, res_count_next;
  logic        res_load, out_load;

  logic          accept, match, scan_end, mtf_end;
  logic          slot_in_range;
  logic [AW+4:0] slot_wide;
  logic [AW-1:0] slot_aw;
  logic [15:0]   cur_count;

  function automatic logic [4:0] slot5(input logic [AW-1:0] s);
    logic [AW+4:0] w;
    w = {5'b0, s};
    return w[4:0];
  endfunction

  function automatic logic [15:0] count_up(input logic [15:0] c);
    return (c == COUNT_MAX) ? c : c + 16'd1;
  endfunction

  assign in_ready      = (state == S_IDLE);
  assign accept        = in_valid && in_ready;
  assign slot_wide     = {{AW{1'b0}}, in_slot};
  assign slot_aw       = slot_wide[AW-1:0];
  assign slot_in_range = ({4'b0, in_slot} < 9'(ENTRIES));
  assign cur_count     = entry_rd_data.count;

  assign match    = (entry_rd_data.obj == obj_q) && (entry_rd_data.dev == dev_q);
  assign scan_end = (state == S_SCAN) && s2 && (match || s2_last);
  assign mtf_end  = (state == S_MTF) && s1 && ((order_rd_data == slot_q) || s1_last);
  assign out_load = (state == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_ACQUIRE) begin
            state_next = S_SCAN;
          end else if (slot_in_range) begin
            state_next = S_SLOT_RD;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH:  state_next = S_EMIT;
      S_SLOT_RD: state_next = S_SLOT_OP;
      S_SLOT_OP: begin
        if (cmd_q == CMD_RELEASE && cur_count == 16'd1) begin
          state_next = S_MTF;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_MTF: begin
        if (mtf_end) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    order_rd_en     = 1'b0;
    order_rd_addr   = rd_pos[AW-1:0];
    order_wr_en     = 1'b0;
    order_wr_addr   = s1_pos;
    order_wr_data   = carry;
    entry_rd_en     = 1'b0;
    entry_rd_addr   = slot_q;
    entry_wr_en     = 1'b0;
    entry_wr_addr   = slot_q;
    entry_wr_data   = entry_rd_data;
    res_load        = 1'b0;
    res_slot_next   = in_slot;
    res_status_next = STAT_DONE;
    res_count_next  = 16'd0;
    unique case (state)
      S_IDLE: begin
        // out-of-range slot: answer at once
        res_load = accept && (in_cmd != CMD_ACQUIRE) && !slot_in_range;
      end
      S_SCAN: begin
        order_rd_en   = (rd_pos < ENTRIES_W) && !scan_end;
        entry_rd_en   = s1 && !scan_end;
        entry_rd_addr = order_rd_data;
      end
      S_FINISH: begin
        res_load = 1'b1;
        if (hit) begin
          entry_wr_en         = 1'b1;
          entry_wr_addr       = hit_slot;
          entry_wr_data.obj   = obj_q;
          entry_wr_data.dev   = dev_q;
          entry_wr_data.count = count_up(hit_count);
          res_slot_next       = slot5(hit_slot);
          res_count_next      = count_up(hit_count);
        end else if (have_free) begin
          entry_wr_en         = 1'b1;
          entry_wr_addr       = free_slot;
          entry_wr_data.obj   = obj_q;
          entry_wr_data.dev   = dev_q;
          entry_wr_data.count = 16'd1;
          res_slot_next       = slot5(free_slot);
          res_status_next     = STAT_CLAIMED;
          res_count_next      = 16'd1;
        end else begin
          res_slot_next   = 5'd0;
          res_status_next = STAT_FULL;
        end
      end
      S_SLOT_RD: begin
        entry_rd_en = 1'b1;
      end
      S_SLOT_OP: begin
        res_load      = 1'b1;
        res_slot_next = slot5(slot_q);
        case (cmd_q)
          CMD_ADDREF: begin
            entry_wr_en         = 1'b1;
            entry_wr_data.count = count_up(cur_count);
            res_count_next      = count_up(cur_count);
          end
          CMD_RELEASE: begin
            if (cur_count == 16'd0) begin
              res_status_next = STAT_REL_ZERO;
            end else begin
              entry_wr_en         = 1'b1;
              entry_wr_data.count = cur_count - 16'd1;
              res_count_next      = cur_count - 16'd1;
            end
          end
          default: begin
            res_count_next = cur_count;
          end
        endcase
      end
      S_MTF: begin
        // shift each position down by one until the released slot is met
        order_rd_en = (rd_pos < ENTRIES_W) && !mtf_end;
        order_wr_en = s1;
      end
      S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      s1        <= 1'b0;
      s2        <= 1'b0;
    end else begin
      state <= state_next;
      s1    <= order_rd_en;
      s2    <= (state == S_SCAN) && s1 && !scan_end;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q     <= in_cmd;
      obj_q     <= in_obj;
      dev_q     <= in_dev;
      slot_q    <= slot_aw;
      rd_pos    <= '0;
      hit       <= 1'b0;
      have_free <= 1'b0;
    end else if (order_rd_en) begin
      rd_pos <= rd_pos + 1'b1;
    end
    s1_pos  <= rd_pos[AW-1:0];
    s1_last <= (rd_pos == LAST_POS);
    s2_last <= s1_last;
    s2_slot <= order_rd_data;
    if (state == S_SCAN && s2) begin
      if (match) begin
        hit       <= 1'b1;
        hit_slot  <= s2_slot;
        hit_count <= cur_count;
      end else if (cur_count == 16'd0) begin
        have_free <= 1'b1;
        free_slot <= s2_slot;
      end
    end
    if (state == S_SLOT_OP) begin
      rd_pos <= '0;
      carry  <= slot_q;
    end else if (state == S_MTF && s1) begin
      carry <= order_rd_data;
    end
    if (res_load) begin
      res_slot   <= res_slot_next;
      res_status <= res_status_next;
      res_count  <= res_count_next;
    end
    if (out_load) begin
      out_slot   <= res_slot;
      out_status <= res_status;
      out_count  <= res_count;
    end
  end

  `RTC_ASSERT_NEXT(a_accept_busy, accept, state != S_IDLE, "accepted beat left block idle")
  `RTC_ASSERT_HOLDS(a_scan_no_write, state == S_SCAN, !entry_wr_en && !order_wr_en,
                    "memory write during list scan")
  `RTC_ASSERT_HOLDS(a_mtf_behind_read, order_wr_en,
                    (state == S_MTF) && ({1'b0, s1_pos} < rd_pos),
                    "order write not behind read pointer")
  `RTC_ASSERT_NEXT(a_emit_hold, (state == S_EMIT) && out_valid && !out_ready,
                   state == S_EMIT, "result dropped while output stalled")

endmodule

`default_nettype wire

@@ test/refcounted_tag_cache_checker.sv @@
// Checker for the tag cache: tracks the table, predicts each result and compares it
`timescale 1ns / 1ps

module tag_cache_checker
  import rtc_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [55:0] s_tdata,   // object_number, device_number, slot_index, pad
  input  wire logic [1:0]  s_tuser,   // cmd
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [23:0] m_tdata,   // result_slot, count_after, pad
  input  wire logic [1:0]  m_tuser,   // status
  output int               fail_count,
  output int               outstanding
);

  typedef struct packed {
    logic [4:0]  slot;
    status_t     status;
    logic [15:0] count;
  } cache_result_t;

  logic [31:0]  tag_obj [ENTRIES];
  logic [15:0]  tag_dev [ENTRIES];
  logic [15:0]  refs    [ENTRIES];
  int unsigned  recency [ENTRIES];   // position 0 is the front

  cache_result_t results_due [$];
  int            errors;

  assign fail_count = errors;

  function automatic logic [15:0] bump(input logic [15:0] c);
    return (c == COUNT_MAX) ? COUNT_MAX : c + 16'd1;
  endfunction

  task automatic move_slot_to_front(input int unsigned slot);
    int pos;
    pos = 0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (recency[i] == slot) pos = i;
    end
    for (int i = pos; i > 0; i--) recency[i] = recency[i - 1];
    recency[0] = slot;
  endtask

  task automatic apply_command(input cmd_t cmd, input logic [31:0] obj,
                               input logic [15:0] dev, input logic [4:0] slot,
                               output cache_result_t res);
    bit          hit;
    bit          have_free;
    int unsigned s;
    int unsigned hit_slot;
    int unsigned free_slot;
    hit = 0;
    have_free = 0;
    hit_slot = 0;
    free_slot = 0;
    res = '0;
    if (cmd == CMD_ACQUIRE) begin
      // first tag match wins; the last free entry seen is nearest the tail
      for (int p = 0; p < ENTRIES; p++) begin
        s = recency[p];
        if (!hit) begin
          if (tag_obj[s] == obj && tag_dev[s] == dev) begin
            hit = 1;
            hit_slot = s;
          end else if (refs[s] == 16'd0) begin
            have_free = 1;
            free_slot = s;
          end
        end
      end
      if (hit) begin
        refs[hit_slot] = bump(refs[hit_slot]);
        res = '{slot: hit_slot[4:0], status: STAT_DONE, count: refs[hit_slot]};
      end else if (have_free) begin
        tag_obj[free_slot] = obj;
        tag_dev[free_slot] = dev;
        refs[free_slot] = 16'd1;
        res = '{slot: free_slot[4:0], status: STAT_CLAIMED, count: 16'd1};
      end else begin
        res = '{slot: 5'd0, status: STAT_FULL, count: 16'd0};
      end
    end else if (int'(slot) >= ENTRIES) begin
      res = '{slot: slot, status: STAT_DONE, count: 16'd0};
    end else if (cmd == CMD_ADDREF) begin
      refs[slot] = bump(refs[slot]);
      res = '{slot: slot, status: STAT_DONE, count: refs[slot]};
    end else if (cmd == CMD_RELEASE) begin
      if (refs[slot] == 16'd0) begin
        res = '{slot: slot, status: STAT_REL_ZERO, count: 16'd0};
      end else begin
        refs[slot] = refs[slot] - 16'd1;
        if (refs[slot] == 16'd0) move_slot_to_front(32'(slot));
        res = '{slot: slot, status: STAT_DONE, count: refs[slot]};
      end
    end else begin
      // unused command: report the slot and leave everything alone
      res = '{slot: slot, status: STAT_DONE, count: refs[slot]};
    end
  endtask

  task automatic note_failure(input string what, input cache_result_t want,
                              input cache_result_t got);
    errors++;
    if (errors <= 10)
      $display("checker: %s: expected slot %0d status %0d count %0d,",
               what, want.slot, want.status, want.count,
               " got slot %0d status %0d count %0d", got.slot, got.status, got.count);
  endtask

  always @(posedge clk) begin
    cache_result_t want;
    cache_result_t got;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tag_obj[i] = '0;
        tag_dev[i] = '0;
        refs[i] = '0;
        recency[i] = i;
      end
      results_due.delete();
      errors = 0;
      outstanding <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{slot: m_tdata[4:0], status: m_tuser, count: m_tdata[20:5]};
        if (results_due.size() == 0) begin
          note_failure("result beat with nothing pending", '0, got);
        end else begin
          want = results_due.pop_front();
          if (want != got) note_failure("result mismatch", want, got);
        end
      end
      if (s_tvalid && s_tready) begin
        apply_command(s_tuser, s_tdata[31:0], s_tdata[47:32], s_tdata[52:48], want);
        results_due.push_back(want);
      end
      outstanding <= results_due.size();
    end
  end

endmodule

@@ test/tb_top.sv @@
// Testbench top for the tag cache: clock, reset, command stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
  import rtc_pkg::*;

  localparam int   ENTRIES      = 32;
  localparam cmd_t CMD_UNUSED   = 2'd3;
  localparam int   RANDOM_ITEMS = 550;
  localparam int   STALL_LIMIT  = 4000;
  localparam int   MODE_FILL    = 0;
  localparam int   MODE_DRAIN   = 1;
  localparam int   MODE_CHURN   = 2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // object_number[31:0], device_number[47:32], slot_index[52:48]
  logic [1:0]  s_tuser = '0;   // cmd[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // result_slot[4:0], count_after[20:5]
  logic [1:0]  m_tuser;        // status[1:0]

  int fail_count;
  int outstanding;
  int items_sent = 0;
  int burst_left = 0;
  int gap_max = 0;
  int idle_cycles = 0;
  bit steady_sink = 1'b0;

  int          sink_mode = 0;
  int          sink_phase = 0;
  logic [2:0]  sink_tick = '0;

  logic [31:0] pool_obj [32];
  logic [15:0] pool_dev [32];

  refcounted_tag_cache_top #(.ENTRIES(ENTRIES)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  tag_cache_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: switch between randomly chosen stall patterns; steady_sink holds m_tready high
  always @(posedge clk) begin
    sink_tick <= sink_tick + 3'd1;
    if (sink_phase == 0) begin
      sink_mode <= $urandom_range(0, 3);
      sink_phase <= $urandom_range(16, 96);
    end else begin
      sink_phase <= sink_phase - 1;
    end
    if (steady_sink) begin
      m_tready <= 1'b1;
    end else begin
      case (sink_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 1) == 1);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (sink_tick < 3'd5);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [15:0] rand_dev();
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [4:0] rand_slot();
    return 5'($urandom_range(0, 31));
  endfunction

  // Hold the beat until the block takes it; valid stays high for a back-to-back beat
  task automatic send_beat(input cmd_t cmd, input logic [31:0] obj,
                           input logic [15:0] dev, input logic [4:0] slot);
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {3'b000, slot, dev, obj};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic paced_beat(input cmd_t cmd, input logic [31:0] obj,
                            input logic [15:0] dev, input logic [4:0] slot);
    int gap;
    send_beat(cmd, obj, dev, slot);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int          mode;
    int          len;
    int          base;
    int          round;
    int          pick;
    int          r;
    logic [31:0] fresh_obj;
    logic [15:0] fresh_dev;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle hit on the reset tag, claim at the tail, release down past zero
    steady_sink = 1'b1;
    send_beat(CMD_ACQUIRE, 32'h0, 16'h0, 5'd0);
    send_beat(CMD_ACQUIRE, 32'hFFFF_FFFF, 16'hFFFF, 5'd31);
    send_beat(CMD_ADDREF, 32'h0, 16'h0, 5'd31);
    send_beat(CMD_RELEASE, 32'hFFFF_FFFF, 16'hFFFF, 5'd31);
    send_beat(CMD_RELEASE, 32'h0, 16'h0, 5'd31);
    send_beat(CMD_RELEASE, 32'h0, 16'h0, 5'd31);
    send_beat(CMD_ACQUIRE, 32'hFFFF_FFFF, 16'hFFFF, 5'd31);
    send_beat(CMD_UNUSED, 32'h0, 16'h0, 5'd31);
    send_beat(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 5'd0);
    send_beat(CMD_RELEASE, 32'h0, 16'h0, 5'd0);
    send_beat(CMD_ACQUIRE, 32'h5555_AAAA, 16'hA5A5, 5'd0);
    send_beat(CMD_ACQUIRE, 32'hAAAA_5555, 16'h5A5A, 5'd21);
    send_beat(CMD_ADDREF, 32'h0, 16'h0, 5'd10);
    send_beat(CMD_RELEASE, 32'h0, 16'h0, 5'd10);
    wait_all_results();
    steady_sink = 1'b0;

    for (int k = 0; k < 32; k++) begin
      pool_obj[k] = $urandom();
      pool_dev[k] = rand_dev();
    end

    base = items_sent;
    round = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      mode = $urandom_range(MODE_FILL, MODE_CHURN);
      len = $urandom_range(15, 40);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 31);
        r = $urandom_range(0, 99);
        case (mode)
          MODE_FILL: begin
            // mostly fresh tags, so the table fills and then reports full
            if (r < 10) begin
              paced_beat(CMD_ACQUIRE, pool_obj[pick], pool_dev[pick], rand_slot());
            end else begin
              fresh_obj = $urandom();
              fresh_dev = rand_dev();
              pool_obj[pick] = fresh_obj;
              pool_dev[pick] = fresh_dev;
              paced_beat(CMD_ACQUIRE, fresh_obj, fresh_dev, rand_slot());
            end
          end
          MODE_DRAIN: begin
            if (r < 10) paced_beat(CMD_ADDREF, $urandom(), rand_dev(), rand_slot());
            else paced_beat(CMD_RELEASE, $urandom(), rand_dev(), rand_slot());
          end
          default: begin
            if (r < 40)
              paced_beat(CMD_ACQUIRE, pool_obj[pick], pool_dev[pick], rand_slot());
            else if (r < 55)
              paced_beat(CMD_ADDREF, $urandom(), rand_dev(), rand_slot());
            else if (r < 90)
              paced_beat(CMD_RELEASE, $urandom(), rand_dev(), rand_slot());
            else if (r < 95)
              paced_beat(CMD_UNUSED, $urandom(), rand_dev(), rand_slot());
            else
              paced_beat(CMD_ACQUIRE, $urandom(), rand_dev(), rand_slot());
          end
        endcase
      end
      round++;
      if (round % 4 == 0) wait_all_results();
    end

    wait_all_results();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/rtc_pkg.sv
hw/rtl/rtc_entry_mem.sv
hw/rtl/rtc_order_mem.sv
hw/rtl/rtc_ctrl.sv
hw/rtl/refcounted_tag_cache_top.sv
test/refcounted_tag_cache_checker.sv
test/tb_top.sv
